@@ rtl/attitude_torque_law_core_defines.svh @@
// assertion macros for the attitude torque law core
// no dependencies
`ifndef ATTITUDE_TORQUE_LAW_CORE_DEFINES_SVH
`define ATTITUDE_TORQUE_LAW_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define ATL_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ATL_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ATL_ASSERT(label, clk, rst_n, prop, msg)
`define ATL_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

@@ rtl/atl_pkg.sv @@
// shared types, constants and helpers for the attitude torque law core
// no dependencies
package atl_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TARGET_QUAT   = 3'd0,
        REG_TARGET_RATE   = 3'd1,
        REG_INERTIA_ROW0  = 3'd2,
        REG_INERTIA_ROW1  = 3'd3,
        REG_INERTIA_ROW2  = 3'd4,
        REG_RATE_GAIN     = 3'd5,
        REG_ATTITUDE_GAIN = 3'd6,
        REG_TORQUE_LIMIT  = 3'd7
    } cfg_reg_t;

    localparam logic [63:0] TARGET_QUAT_RST = 64'h7FFF_0000_0000_0000;
    localparam logic [15:0] RATE_GAIN_RST   = 16'd3277;
    localparam logic [15:0] ATT_GAIN_RST    = 16'd328;
    localparam logic [30:0] TORQUE_LIM_RST  = 31'd1073742;

    // magnitude root and quotient width
    localparam int ROOT_W = 33;
    localparam int QUO_W  = 62;

    typedef struct packed {
        logic signed [23:0] rate_x;
        logic signed [23:0] rate_y;
        logic signed [23:0] rate_z;
        logic signed [15:0] quat_w;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] torque_x;
        logic signed [31:0] torque_y;
        logic signed [31:0] torque_z;
        logic               limited;
    } out_item_t;

    typedef struct packed {
        logic [63:0] target_quat;
        logic [62:0] target_rate;
        logic [62:0] inertia_row0;
        logic [62:0] inertia_row1;
        logic [62:0] inertia_row2;
        logic [15:0] rate_gain;
        logic [15:0] attitude_gain;
        logic [30:0] torque_limit;
    } cfg_t;

    // per-stage handshake control
    typedef struct packed {
        logic valid;
        logic advance;
    } stage_ctl_t;

    function automatic logic signed [20:0] fld21(input logic [62:0] r, input int idx);
        fld21 = r[62 - 21*idx -: 21];
    endfunction

    function automatic logic signed [127:0] rnd_sh(input logic signed [127:0] v,
                                                   input int n);
        rnd_sh = (v + (128'sd1 <<< (n - 1))) >>> n;
    endfunction

endpackage

@@ rtl/atl_stream_if.sv @@
// valid/ready stream channel carrying one payload beat
// no dependencies
interface atl_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/atl_cfg_regs.sv @@
// configuration register file for the attitude torque law core
// depends on atl_pkg
module atl_cfg_regs
    import atl_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);
    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{TARGET_QUAT_RST, 63'd0, 63'd0, 63'd0, 63'd0,
                         RATE_GAIN_RST, ATT_GAIN_RST, TORQUE_LIM_RST};
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_TARGET_QUAT:   cfg_reg.target_quat   <= cfg_data;
                REG_TARGET_RATE:   cfg_reg.target_rate   <= cfg_data[62:0];
                REG_INERTIA_ROW0:  cfg_reg.inertia_row0  <= cfg_data[62:0];
                REG_INERTIA_ROW1:  cfg_reg.inertia_row1  <= cfg_data[62:0];
                REG_INERTIA_ROW2:  cfg_reg.inertia_row2  <= cfg_data[62:0];
                REG_RATE_GAIN:     cfg_reg.rate_gain     <= cfg_data[15:0];
                REG_ATTITUDE_GAIN: cfg_reg.attitude_gain <= cfg_data[15:0];
                REG_TORQUE_LIMIT:  cfg_reg.torque_limit  <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;
endmodule

@@ rtl/atl_law_pipe.sv @@
// control law datapath: inertia products, quaternion error, gains, sum
// depends on atl_pkg and the defines header; four register stages with valid bits and stall
module atl_law_pipe
    import atl_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  logic               in_valid,
    output logic               in_ready,
    input  in_item_t           in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [63:0] out_t [3]
);
    // stage 1: w, e, quaternion error, w*I and e*I products
    logic               v1_reg;
    logic signed [23:0] w1_reg [3];
    logic signed [63:0] wi1_reg [3];
    logic signed [63:0] ei1_reg [3];
    logic signed [35:0] q1_reg [3];
    // stage 2: h, v*I products, gains on e*I
    logic               v2_reg;
    logic signed [23:0] w2_reg [3];
    logic signed [63:0] h2_reg [3];
    logic signed [63:0] vi2_reg [3];
    logic signed [63:0] re2_reg [3];
    // stage 3: cross product and attitude term
    logic               v3_reg;
    logic signed [63:0] t3_reg [3];
    // stage 4: result
    logic               v4_reg;
    logic signed [63:0] t4_reg [3];

    stage_ctl_t s1, s2, s3, s4;

    always_comb
    begin
        s4.valid   = v4_reg;
        s4.advance = !v4_reg || out_ready;
        s3.valid   = v3_reg;
        s3.advance = !v3_reg || s4.advance;
        s2.valid   = v2_reg;
        s2.advance = !v2_reg || s3.advance;
        s1.valid   = v1_reg;
        s1.advance = !v1_reg || s2.advance;
    end
    assign in_ready  = s1.advance;
    assign out_valid = s4.valid;

    logic signed [23:0] w_in [3];
    logic signed [24:0] e_in [3];
    logic signed [20:0] inr [3][3];
    logic signed [15:0] dw, dx, dy, dz;

    always_comb
    begin
        w_in[0] = in_data.rate_x;
        w_in[1] = in_data.rate_y;
        w_in[2] = in_data.rate_z;
        for (int i = 0; i < 3; i++)
        begin
            e_in[i] = 25'(w_in[i]) - 25'(fld21(cfg.target_rate, i));
            inr[0][i] = fld21(cfg.inertia_row0, i);
            inr[1][i] = fld21(cfg.inertia_row1, i);
            inr[2][i] = fld21(cfg.inertia_row2, i);
        end
        dw = cfg.target_quat[63:48];
        dx = cfg.target_quat[47:32];
        dy = cfg.target_quat[31:16];
        dz = cfg.target_quat[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (s1.advance) v1_reg <= in_valid;
            if (s2.advance) v2_reg <= v1_reg;
            if (s3.advance) v3_reg <= v2_reg;
            if (s4.advance) v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1.advance)
        begin
            for (int j = 0; j < 3; j++)
            begin
                w1_reg[j]  <= w_in[j];
                wi1_reg[j] <= 64'(w_in[0] * inr[0][j]) + 64'(w_in[1] * inr[1][j])
                              + 64'(w_in[2] * inr[2][j]);
                ei1_reg[j] <= 64'(e_in[0] * inr[0][j]) + 64'(e_in[1] * inr[1][j])
                              + 64'(e_in[2] * inr[2][j]);
            end
            q1_reg[0] <= 36'(dw * in_data.quat_x) + 36'(dz * in_data.quat_y)
                         - 36'(dy * in_data.quat_z) - 36'(dx * in_data.quat_w);
            q1_reg[1] <= 36'(dw * in_data.quat_y) - 36'(dz * in_data.quat_x)
                         + 36'(dx * in_data.quat_z) - 36'(dy * in_data.quat_w);
            q1_reg[2] <= 36'(dy * in_data.quat_x) - 36'(dx * in_data.quat_y)
                         + 36'(dw * in_data.quat_z) - 36'(dz * in_data.quat_w);
        end
        if (s2.advance)
        begin
            for (int j = 0; j < 3; j++)
            begin
                logic signed [26:0] vq [3];
                for (int i = 0; i < 3; i++)
                    vq[i] = 27'(rnd_sh(128'(q1_reg[i]), 10));
                w2_reg[j]  <= w1_reg[j];
                h2_reg[j]  <= 64'(rnd_sh(128'(wi1_reg[j]), 10));
                vi2_reg[j] <= 64'(vq[0] * inr[0][j]) + 64'(vq[1] * inr[1][j])
                              + 64'(vq[2] * inr[2][j]);
                re2_reg[j] <= 64'(rnd_sh(128'(ei1_reg[j]) * $signed({1'b0, cfg.rate_gain}),
                                         16));
            end
        end
        if (s3.advance)
        begin
            for (int j = 0; j < 3; j++)
            begin
                logic signed [127:0] cr;
                logic signed [127:0] at;
                cr = 128'(w2_reg[(j+1)%3]) * h2_reg[(j+2)%3]
                     - 128'(w2_reg[(j+2)%3]) * h2_reg[(j+1)%3];
                at = rnd_sh(128'(vi2_reg[j]) * $signed({1'b0, cfg.attitude_gain}), 16);
                t3_reg[j] <= 64'(rnd_sh(cr, 10)) - re2_reg[j] - 64'(at);
            end
        end
        if (s4.advance)
        begin
            for (int j = 0; j < 3; j++)
                t4_reg[j] <= t3_reg[j];
        end
    end

    assign out_t = t4_reg;

    `include "attitude_torque_law_core_defines.svh"
    `ATL_ASSERT(a_out_hold, clk, rst_n, (out_valid && !out_ready) |=> out_valid, "result lost under stall")
    `ATL_ASSERT(a_ready, clk, rst_n, (!out_valid) |-> in_ready, "pipe blocked while output empty")
    `ATL_ASSERT(a_s3_stall, clk, rst_n, (v3_reg && !s3.advance) |=> v3_reg, "stage 3 beat dropped")
endmodule

@@ rtl/atl_limiter.sv @@
// magnitude limiter: square test, normalise, bit-serial root and divides
// depends on atl_pkg and the defines header; a unit pipeline of root and quotient steps
module atl_limiter
    import atl_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [30:0]        limit,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [63:0] in_t [3],
    output logic               out_valid,
    input  logic               out_ready,
    output out_item_t          out_data
);
    localparam int NST = ROOT_W + QUO_W + 2;

    // stage 0: magnitudes, over flag, normalised magnitudes
    logic        va_reg;
    logic        neg_a_reg [3];
    logic [63:0] t_a_reg [3];
    logic [30:0] a_a_reg [3];
    logic        over_a_reg;
    // stage 1: sum of squares
    logic        vb_reg;
    logic        neg_b_reg [3];
    logic [63:0] t_b_reg [3];
    logic [30:0] a_b_reg [3];
    logic        over_b_reg;
    logic [63:0] m_b_reg;

    // serial chain: limit-square test, then root bits and quotient bits, at most one bit per stage
    logic        vs_reg [NST];
    logic        neg_s_reg [NST][3];
    logic [31:0] t_s_reg [NST][3];
    logic        over_s_reg [NST];
    logic [63:0] rem_s_reg [NST];
    logic [32:0] root_s_reg [NST];
    logic [61:0] num_s_reg [NST][3];
    logic [62:0] qr_s_reg [NST][3];
    logic [61:0] quo_s_reg [NST][3];

    logic adv [NST+2];
    always_comb
    begin
        adv[NST+1] = !vs_reg[NST-1] || out_ready;
        for (int k = NST; k >= 2; k--)
            adv[k] = !vs_reg[k-2] || adv[k+1];
        adv[1] = !vb_reg || adv[2];
        adv[0] = !va_reg || adv[1];
    end
    assign in_ready = adv[0];

    logic [63:0] mag [3];
    logic        ov_c;
    logic [5:0]  sh;
    logic [63:0] orall;
    always_comb
    begin
        ov_c = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = in_t[i][63] ? 64'(-in_t[i]) : 64'(in_t[i]);
            if (mag[i] > 64'(limit)) ov_c = 1'b1;
        end
        orall = mag[0] | mag[1] | mag[2];
        sh = 6'd0;
        for (int b = 31; b < 64; b++)
            if (orall[b]) sh = 6'(b - 30);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            for (int k = 0; k < NST; k++)
                vs_reg[k] <= 1'b0;
        end
        else
        begin
            if (adv[0]) va_reg <= in_valid;
            if (adv[1]) vb_reg <= va_reg;
            if (adv[2]) vs_reg[0] <= vb_reg;
            for (int k = 1; k < NST; k++)
                if (adv[k+2]) vs_reg[k] <= vs_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            over_a_reg <= ov_c;
            for (int i = 0; i < 3; i++)
            begin
                neg_a_reg[i] <= in_t[i][63];
                t_a_reg[i]   <= in_t[i];
                a_a_reg[i]   <= 31'(mag[i] >> sh);
            end
        end
        if (adv[1])
        begin
            // if no component exceeds the limit the magnitudes are already normalised
            m_b_reg <= 64'(a_a_reg[0] * a_a_reg[0]) + 64'(a_a_reg[1] * a_a_reg[1])
                       + 64'(a_a_reg[2] * a_a_reg[2]);
            over_b_reg <= over_a_reg;
            for (int i = 0; i < 3; i++)
            begin
                neg_b_reg[i] <= neg_a_reg[i];
                t_b_reg[i]   <= t_a_reg[i];
                a_b_reg[i]   <= a_a_reg[i];
            end
        end
        for (int k = 0; k < NST; k++)
        begin
            if (adv[k+2])
            begin
                logic [63:0] rem;
                logic [32:0] rt;
                logic        ov;
                logic [64:0] trial;
                logic [63:0] cand;
                ov  = (k == 0) ? over_b_reg : over_s_reg[k-1];
                rem = (k == 0) ? m_b_reg : rem_s_reg[k-1];
                rt  = (k == 0) ? 33'd0 : root_s_reg[k-1];
                if (k == 0)
                begin
                    // compare against limit squared
                    ov = ov || (m_b_reg > 64'(limit) * 64'(limit));
                end
                else if (k <= 32)
                begin
                    // trial term is (4r + 1) at this bit pair
                    cand = 64'({rt, 2'b01}) << (2 * (32 - k));
                    trial = {1'b0, rem} - {1'b0, cand};
                    if (!trial[64])
                    begin
                        rem = trial[63:0];
                        rt  = {rt[31:0], 1'b1};
                    end
                    else
                        rt = {rt[31:0], 1'b0};
                end
                over_s_reg[k] <= ov;
                rem_s_reg[k]  <= rem;
                root_s_reg[k] <= rt;
                for (int i = 0; i < 3; i++)
                begin
                    logic [61:0] num;
                    logic [62:0] qr;
                    logic [61:0] qo;
                    logic [63:0] d;
                    num = (k == 0) ? 62'(a_b_reg[i]) * 62'(limit) : num_s_reg[k-1][i];
                    qr  = (k == 0) ? 63'd0 : qr_s_reg[k-1][i];
                    qo  = (k == 0) ? 62'd0 : quo_s_reg[k-1][i];
                    if (k > 32 && k <= 32 + QUO_W)
                    begin
                        qr = {qr[61:0], num[61 - (k - 33)]};
                        d  = {1'b0, qr} - 64'(rt);
                        if (!d[63] && rt != 33'd0)
                        begin
                            qr = d[62:0];
                            qo = {qo[60:0], 1'b1};
                        end
                        else
                            qo = {qo[60:0], 1'b0};
                    end
                    num_s_reg[k][i] <= num;
                    qr_s_reg[k][i]  <= qr;
                    quo_s_reg[k][i] <= qo;
                    neg_s_reg[k][i] <= (k == 0) ? neg_b_reg[i] : neg_s_reg[k-1][i];
                    t_s_reg[k][i]   <= (k == 0) ? t_b_reg[i][31:0] : t_s_reg[k-1][i];
                end
            end
        end
    end

    logic [31:0] res [3];
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (!over_s_reg[NST-1])
                res[i] = t_s_reg[NST-1][i];
            else if (neg_s_reg[NST-1][i])
                res[i] = 32'(-quo_s_reg[NST-1][i]);
            else
                res[i] = quo_s_reg[NST-1][i][31:0];
        end
    end
    assign out_valid         = vs_reg[NST-1];
    assign out_data.torque_x = res[0];
    assign out_data.torque_y = res[1];
    assign out_data.torque_z = res[2];
    assign out_data.limited  = over_s_reg[NST-1];

    `include "attitude_torque_law_core_defines.svh"
    `ATL_ASSERT(a_lim_hold, clk, rst_n, (out_valid && !out_ready) |=> out_valid, "limiter result dropped")
    `ATL_ASSERT(a_lim_bound, clk, rst_n, (out_valid && out_data.limited) |-> (quo_s_reg[NST-1][0] <= 62'(limit)), "scaled torque over limit")
    `ATL_ASSERT(a_lim_ready, clk, rst_n, (!out_valid) |-> in_ready, "limiter blocked while empty")
endmodule

@@ rtl/attitude_torque_law_core.sv @@
// 4 law stages plus 2 limiter stages plus 97 serial stages for the limit-square test, root and divide
// throughput: one beat per cycle while the output is taken, set by the fully unrolled root and quotient chain
// reset clears all valid bits and loads register defaults; an item is accepted
// every cycle while the output is taken
// depends on atl_pkg, atl_stream_if, atl_cfg_regs, atl_law_pipe, atl_limiter
module attitude_torque_law_core
    import atl_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    atl_stream_if.sink            in_ch,
    atl_stream_if.source          out_ch
);
    cfg_t               cfg;
    logic               mid_valid;
    logic               mid_ready;
    logic signed [63:0] mid_t [3];
    out_item_t          res;

    atl_cfg_regs u_cfg (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .cfg(cfg)
    );

    atl_law_pipe u_law (
        .clk(clk), .rst_n(rst_n), .cfg(cfg),
        .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
        .out_valid(mid_valid), .out_ready(mid_ready), .out_t(mid_t)
    );

    atl_limiter u_lim (
        .clk(clk), .rst_n(rst_n), .limit(cfg.torque_limit),
        .in_valid(mid_valid), .in_ready(mid_ready), .in_t(mid_t),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(res)
    );

    assign out_ch.data = res;
endmodule

@@ tb/atl_torque_checker.sv @@
// checker for the attitude torque law core: watches both channels and the register port,
// predicts each torque from its own copy of the registers and compares beat by beat
// depends on atl_pkg and atl_stream_if
`timescale 1ns / 1ps

module atl_torque_checker
    import atl_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    atl_stream_if                 in_ch,
    atl_stream_if                 out_ch,
    output int                    fails,
    output int                    pending
);

    typedef logic signed [127:0] wide_t;

    logic [63:0] tgt_quat;
    logic [62:0] tgt_rate;
    logic [62:0] inertia [3];
    logic [15:0] kw;
    logic [15:0] kq;
    logic [30:0] lim;

    out_item_t pred_fifo[$];

    function automatic logic signed [20:0] pick21(input logic [62:0] r, input int idx);
        return r[62 - 21*idx -: 21];
    endfunction

    function automatic wide_t round_shift(input wide_t v, input int n);
        wide_t one;
        one = 1;
        return (v + (one <<< (n - 1))) >>> n;
    endfunction

    // row vector times inertia matrix
    function automatic void mul_inertia(input wide_t v [3], output wide_t r [3]);
        wide_t el;
        for (int j = 0; j < 3; j++)
        begin
            r[j] = 0;
            for (int i = 0; i < 3; i++)
            begin
                el = pick21(inertia[i], j);
                r[j] = r[j] + v[i] * el;
            end
        end
    endfunction

    function automatic out_item_t torque_law(input in_item_t it);
        wide_t w [3], e [3], h [3], wi [3], ei [3], vq [3], vi [3], t [3];
        wide_t qw, qx, qy, qz, dw, dx, dy, dz, gw, gq, tmp;
        logic [127:0] a [3], l, m2, root, cand, mag;
        bit over;
        int s;
        out_item_t r;
        w[0] = it.rate_x;
        w[1] = it.rate_y;
        w[2] = it.rate_z;
        for (int i = 0; i < 3; i++)
        begin
            tmp = pick21(tgt_rate, i);
            e[i] = w[i] - tmp;
        end
        qw = it.quat_w;
        qx = it.quat_x;
        qy = it.quat_y;
        qz = it.quat_z;
        dw = $signed(tgt_quat[63:48]);
        dx = $signed(tgt_quat[47:32]);
        dy = $signed(tgt_quat[31:16]);
        dz = $signed(tgt_quat[15:0]);
        gw = {112'd0, kw};
        gq = {112'd0, kq};
        l  = {97'd0, lim};

        mul_inertia(w, wi);
        for (int i = 0; i < 3; i++)
            h[i] = round_shift(wi[i], 10);
        mul_inertia(e, ei);
        vq[0] = round_shift(dw*qx + dz*qy - dy*qz - dx*qw, 10);
        vq[1] = round_shift(-dz*qx + dw*qy + dx*qz - dy*qw, 10);
        vq[2] = round_shift(dy*qx - dx*qy + dw*qz - dz*qw, 10);
        mul_inertia(vq, vi);

        t[0] = round_shift(w[1]*h[2] - w[2]*h[1], 10);
        t[1] = round_shift(w[2]*h[0] - w[0]*h[2], 10);
        t[2] = round_shift(w[0]*h[1] - w[1]*h[0], 10);
        over = 0;
        for (int i = 0; i < 3; i++)
        begin
            t[i] = t[i] - round_shift(gw * ei[i], 16) - round_shift(gq * vi[i], 16);
            a[i] = (t[i] < 0) ? -t[i] : t[i];
            if (a[i] > l)
                over = 1;
        end
        m2 = a[0]*a[0] + a[1]*a[1] + a[2]*a[2];
        if (m2 > l*l)
            over = 1;

        if (over)
        begin
            s = 0;
            while ((a[0] >> s) >= 2**31 || (a[1] >> s) >= 2**31 || (a[2] >> s) >= 2**31)
                s++;
            for (int i = 0; i < 3; i++)
                a[i] = a[i] >> s;
            m2 = a[0]*a[0] + a[1]*a[1] + a[2]*a[2];
            root = 0;
            for (int b = 33; b >= 0; b--)
            begin
                cand = root | (128'd1 << b);
                if (cand * cand <= m2)
                    root = cand;
            end
            for (int i = 0; i < 3; i++)
            begin
                mag = (root != 0) ? (a[i] * l) / root : 0;
                t[i] = (t[i] < 0) ? -$signed(mag) : $signed(mag);
            end
        end
        r.torque_x = t[0][31:0];
        r.torque_y = t[1][31:0];
        r.torque_z = t[2][31:0];
        r.limited  = over;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tgt_quat   <= TARGET_QUAT_RST;
            tgt_rate   <= '0;
            inertia[0] <= '0;
            inertia[1] <= '0;
            inertia[2] <= '0;
            kw         <= RATE_GAIN_RST;
            kq         <= ATT_GAIN_RST;
            lim        <= TORQUE_LIM_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_TARGET_QUAT:   tgt_quat   <= cfg_data;
                REG_TARGET_RATE:   tgt_rate   <= cfg_data[62:0];
                REG_INERTIA_ROW0:  inertia[0] <= cfg_data[62:0];
                REG_INERTIA_ROW1:  inertia[1] <= cfg_data[62:0];
                REG_INERTIA_ROW2:  inertia[2] <= cfg_data[62:0];
                REG_RATE_GAIN:     kw         <= cfg_data[15:0];
                REG_ATTITUDE_GAIN: kq         <= cfg_data[15:0];
                REG_TORQUE_LIMIT:  lim        <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    initial
    begin
        fails   = 0;
        pending = 0;
    end

    always @(posedge clk)
    begin
        out_item_t got, want;
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                got = out_ch.data;
                if (pred_fifo.size() == 0)
                begin
                    $error("torque beat with nothing expected");
                    fails++;
                end
                else
                begin
                    want = pred_fifo.pop_front();
                    if (got.torque_x !== want.torque_x)
                    begin
                        $error("torque_x expected %0d got %0d", want.torque_x, got.torque_x);
                        fails++;
                    end
                    if (got.torque_y !== want.torque_y)
                    begin
                        $error("torque_y expected %0d got %0d", want.torque_y, got.torque_y);
                        fails++;
                    end
                    if (got.torque_z !== want.torque_z)
                    begin
                        $error("torque_z expected %0d got %0d", want.torque_z, got.torque_z);
                        fails++;
                    end
                    if (got.limited !== want.limited)
                    begin
                        $error("limited expected %0d got %0d", want.limited, got.limited);
                        fails++;
                    end
                end
            end
            if (in_ch.valid && in_ch.ready)
                pred_fifo.push_back(torque_law(in_ch.data));
            pending = pred_fifo.size();
        end
    end

endmodule

@@ tb/tb_top.sv @@
// top of the attitude torque law testbench: clock, reset, register writes and stimulus
// depends on atl_pkg, atl_stream_if, atl_torque_checker and the core
`timescale 1ns / 1ps

module tb_top;
    import atl_pkg::*;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fails;
    int                    pending;
    bit                    long_hold_req;
    bit                    no_gaps;
    int                    stall_left;

    atl_stream_if #(.T(in_item_t))  in_ch ();
    atl_stream_if #(.T(out_item_t)) out_ch ();

    attitude_torque_law_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    atl_torque_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .fails     (fails),
        .pending   (pending)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic signed [23:0] pick_rate();
        case ($urandom_range(0, 4))
            0: return 24'($urandom);
            1: return 24'(int'($urandom_range(0, 8191)) - 4096);
            2: return $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
            default: return 24'(int'($urandom_range(0, 524287)) - 262144);
        endcase
    endfunction

    function automatic logic signed [15:0] pick_quat();
        case ($urandom_range(0, 3))
            0: return 16'($urandom);
            1: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            default: return 16'(int'($urandom_range(0, 4095)) - 2048);
        endcase
    endfunction

    function automatic in_item_t random_item();
        in_item_t it;
        it.rate_x = pick_rate();
        it.rate_y = pick_rate();
        it.rate_z = pick_rate();
        it.quat_w = pick_quat();
        it.quat_x = pick_quat();
        it.quat_y = pick_quat();
        it.quat_z = pick_quat();
        return it;
    endfunction

    // three 21-bit entries; mostly small so the limiter is not always engaged
    function automatic logic [62:0] pick_row(input int diag);
        logic [20:0] f [3];
        for (int j = 0; j < 3; j++)
        begin
            if ($urandom_range(0, 3) == 0)
                f[j] = 21'($urandom);
            else if (j == diag)
                f[j] = 21'($urandom_range(512, 8192));
            else
                f[j] = 21'(int'($urandom_range(0, 255)) - 128);
        end
        return {f[0], f[1], f[2]};
    endfunction

    // write enable stays high across back to back writes; caller drops it
    task automatic write_reg(input cfg_reg_t idx, input logic [63:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    task automatic write_all(input logic [63:0] q, input logic [62:0] rt,
                             input logic [62:0] r0, input logic [62:0] r1,
                             input logic [62:0] r2, input logic [15:0] gw,
                             input logic [15:0] gq, input logic [30:0] l);
        wait (pending == 0);
        @(posedge clk);
        write_reg(REG_TARGET_QUAT, q);
        write_reg(REG_TARGET_RATE, {1'b0, rt});
        write_reg(REG_INERTIA_ROW0, {1'b0, r0});
        write_reg(REG_INERTIA_ROW1, {1'b0, r1});
        write_reg(REG_INERTIA_ROW2, {1'b0, r2});
        write_reg(REG_RATE_GAIN, {48'd0, gw});
        write_reg(REG_ATTITUDE_GAIN, {48'd0, gq});
        write_reg(REG_TORQUE_LIMIT, {33'd0, l});
        cfg_we <= 1'b0;
    endtask

    // called at a rising edge; returns at the edge that takes the beat
    task automatic send(input in_item_t it);
        int gap;
        gap = no_gaps ? 0 : idle_len();
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        forever
        begin
            @(negedge clk);
            if (in_ch.ready)
                break;
        end
        @(posedge clk);
    endtask

    task automatic send_q(input logic signed [23:0] rx, input logic signed [23:0] ry,
                          input logic signed [23:0] rz, input logic signed [15:0] qw,
                          input logic signed [15:0] qx, input logic signed [15:0] qy,
                          input logic signed [15:0] qz);
        in_item_t it;
        it = '{rx, ry, rz, qw, qx, qy, qz};
        send(it);
    endtask

    // receiver: random stalls plus one long hold-off on request
    initial
    begin
        out_ch.ready = 1'b0;
        stall_left   = 0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end
            else if (long_hold_req)
            begin
                long_hold_req = 0;
                stall_left    = 400;
                out_ch.ready <= 1'b0;
            end
            else if ($urandom_range(0, 9) == 0)
            begin
                stall_left    = idle_len();
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    initial
    begin
        #5ms;
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        logic [62:0] r0, r1, r2;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        in_ch.valid   = 1'b0;
        in_ch.data    = '0;
        long_hold_req = 0;
        no_gaps       = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // register defaults: zero inertia gives zero torque
        send_q(0, 0, 0, 16'sh7FFF, 0, 0, 0);
        send_q(24'sh7FFFFF, 24'sh800000, 1, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF);
        in_ch.valid <= 1'b0;
        @(posedge clk);

        for (int p = 0; p < 8; p++)
        begin
            r0 = pick_row(0);
            r1 = pick_row(1);
            r2 = pick_row(2);
            case (p)
                0: write_all(TARGET_QUAT_RST, '0, {21'd1024, 42'd0},
                             {21'd0, 21'd2048, 21'd0}, {42'd0, 21'd3072},
                             RATE_GAIN_RST, ATT_GAIN_RST, TORQUE_LIM_RST);
                // everything at its top or most negative value
                3: write_all({4{16'h8000}}, {3{21'h100000}}, {3{21'h100000}},
                             {3{21'h0FFFFF}}, {3{21'h100000}}, 16'hFFFF, 16'hFFFF,
                             31'h7FFFFFFF);
                // zero gains and a zero limit
                5: write_all(64'($urandom), 63'({$urandom, $urandom}), r0, r1, r2,
                             16'd0, 16'd0, 31'd0);
                6: write_all({$urandom, $urandom}, 63'({$urandom, $urandom}), r0, r1, r2,
                             16'($urandom), 16'($urandom), 31'($urandom_range(1, 1000)));
                default: write_all({$urandom, $urandom}, 63'({$urandom, $urandom}),
                                   r0, r1, r2, 16'($urandom), 16'($urandom),
                                   31'($urandom));
            endcase

            if (p == 0)
            begin
                send_q(0, 0, 0, 0, 0, 0, 0);
                send_q(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 16'sh7FFF, 0, 0, 0);
                send_q(24'sh800000, 24'sh800000, 24'sh800000, 16'sh8000, 0, 0, 0);
                send_q(24'sh7FFFFF, 24'sh800000, 0, 0, 16'sh7FFF, 0, 0);
                send_q(0, 24'sh7FFFFF, 24'sh800000, 0, 0, 16'sh8000, 0);
                send_q(1024, -1024, 512, 0, 0, 0, 16'sh7FFF);
                send_q(0, 0, 0, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
                send_q(0, 0, 0, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
                send_q(-1, -1, -1, -1, -1, -1, -1);
                send_q(100, 200, 300, 23170, 23170, 0, 0);
                send_q(-5000, 4000, -3000, 16'sh7FFF, 300, -300, 150);
                send_q(24'sh400000, 0, 0, 0, 0, 0, 0);
            end
            if (p == 5)
                send_q(0, 0, 0, 0, 0, 0, 0);

            // hold the receiver off while items keep coming in back to back
            if (p == 2)
            begin
                no_gaps       = 1;
                long_hold_req = 1;
            end
            for (int k = 0; k < 180; k++)
            begin
                if (p == 4 && k == 90)
                begin
                    in_ch.valid <= 1'b0;
                    wait (pending == 0);
                    @(posedge clk);
                end
                if (p == 2 && k == 150)
                    no_gaps = 0;
                send(random_item());
            end
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end

        wait (pending == 0);
        repeat (120) @(posedge clk);
        if (fails == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
